[rtl/directional_focus_search_unit_macros.svh]
// Assertion macros for the directional focus search unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef DIRECTIONAL_FOCUS_SEARCH_UNIT_MACROS_SVH
`define DIRECTIONAL_FOCUS_SEARCH_UNIT_MACROS_SVH

// Condition must never be true outside reset.
`define DFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/dfs_pkg.sv]
// Shared constants, types and helpers of the directional focus search unit.
// No dependencies.
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_ID_BITS    = 16;

  // Measure: unsigned fixed point, 4 fraction bits
  localparam int MEAS_BITS = 22;
  localparam int FRAC_BITS = 4;
  localparam logic [MEAS_BITS-1:0] MEAS_NONE = '1;
  localparam logic [MEAS_BITS-1:0] MEAS_SAT  = {{(MEAS_BITS-1){1'b1}}, 1'b0};

  // Front/back queue depth (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CUR_LEFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CUR_TOP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CUR_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CUR_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y      = 3'd5;

  // How the back end has to treat a candidate
  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,  // not focusable, current, or behind the current rect
    KIND_ZERO = 2'd1,  // overlaps on both axes, no edge gap
    KIND_AXIS = 2'd2,  // overlaps on one axis, gap is the other axis
    KIND_DIAG = 2'd3   // corner to corner, needs the square root
  } kind_e;

  // Decoded search direction
  typedef struct packed {
    logic x_pos;
    logic x_neg;
    logic y_pos;
    logic y_neg;
  } dir_t;

  // Queue entry: {last, id, gap_b, gap_a, proj_gap, kind}
  function automatic int ent_width(input int coord_bits, input int id_bits);
    return $bits(kind_e) + (coord_bits + 2) + 2 * coord_bits + id_bits + 1;
  endfunction

endpackage

[rtl/dfs_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module dfs_isqrt #(
  parameter int ROOT_W = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*ROOT_W-1:0]   opnd_i,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2*ROOT_W-1:0] opnd_q;
  logic [ROOT_W+1:0]   rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]   root_q, root_d;

  assign done_o = busy_q && (cnt_q == CNT_W'(ROOT_W));
  assign root_o = root_q;

  // Restoring digit recurrence: bring down two operand bits, try 4r+1
  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], opnd_q[2*ROOT_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= opnd_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && !done_o) begin
      opnd_q <= opnd_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

endmodule

[rtl/dfs_queue.sv]
// Small first-word-fall-through queue between front and back end.
// Depends on nothing but its parameters; DEPTH must be a power of two.
`timescale 1ns / 1ps

module dfs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

[rtl/dfs_front.sv]
// Front end: registers one candidate, projects it on the direction and
// classifies it into a queue entry. Depends on dfs_pkg.
`timescale 1ns / 1ps

module dfs_front import dfs_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ID_BITS    = DEF_ID_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] cand_left_i,
  input  logic signed [COORD_BITS-1:0] cand_top_i,
  input  logic signed [COORD_BITS-1:0] cand_right_i,
  input  logic signed [COORD_BITS-1:0] cand_bottom_i,
  input  logic                         cand_focusable_i,
  input  logic                         cand_is_current_i,
  input  logic [ID_BITS-1:0]           cand_id_i,
  input  logic                         last_i,
  input  logic signed [COORD_BITS-1:0] cur_left_i,
  input  logic signed [COORD_BITS-1:0] cur_top_i,
  input  logic signed [COORD_BITS-1:0] cur_right_i,
  input  logic signed [COORD_BITS-1:0] cur_bottom_i,
  input  dir_t                         dir_i,
  output logic                         q_push_o,
  output logic [ent_width(COORD_BITS, ID_BITS)-1:0] q_entry_o,
  input  logic                         q_full_i
);

  localparam int PW  = COORD_BITS + 1;  // one axis projection
  localparam int DW  = COORD_BITS + 3;  // projection difference
  localparam int DPW = COORD_BITS + 2;  // non-negative projection gap
  localparam int XW  = COORD_BITS + 1;  // edge offset

  logic                         item_v_q;
  logic signed [COORD_BITS-1:0] nl_q, nt_q, nr_q, nb_q;
  logic                         focusable_q, is_cur_q, last_q;
  logic [ID_BITS-1:0]           id_q;

  logic signed [COORD_BITS-1:0] nx_lo, nx_hi, ny_lo, ny_hi;
  logic signed [COORD_BITS-1:0] cx_lo, cx_hi, cy_lo, cy_hi;
  logic signed [PW-1:0]         cand_x, cand_y, cur_x, cur_y;
  logic signed [DW-1:0]         dp;
  logic signed [XW-1:0]         xa, xb, ya, yb, xoff, yoff;
  logic [COORD_BITS-1:0]        gap_x, gap_y, gap_a, gap_b;
  kind_e                        kind;

  assign in_ready_o = !item_v_q || !q_full_i;
  assign q_push_o   = item_v_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_ready_o) begin
      item_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      nl_q        <= cand_left_i;
      nt_q        <= cand_top_i;
      nr_q        <= cand_right_i;
      nb_q        <= cand_bottom_i;
      focusable_q <= cand_focusable_i;
      is_cur_q    <= cand_is_current_i;
      id_q        <= cand_id_i;
      last_q      <= last_i;
    end
  end

  always_comb begin
    nx_lo = (nl_q < nr_q) ? nl_q : nr_q;
    nx_hi = (nl_q < nr_q) ? nr_q : nl_q;
    ny_lo = (nt_q < nb_q) ? nt_q : nb_q;
    ny_hi = (nt_q < nb_q) ? nb_q : nt_q;
    cx_lo = (cur_left_i < cur_right_i) ? cur_left_i : cur_right_i;
    cx_hi = (cur_left_i < cur_right_i) ? cur_right_i : cur_left_i;
    cy_lo = (cur_top_i < cur_bottom_i) ? cur_top_i : cur_bottom_i;
    cy_hi = (cur_top_i < cur_bottom_i) ? cur_bottom_i : cur_top_i;

    // least candidate corner and greatest current corner on the direction
    if (dir_i.x_pos) begin
      cand_x = PW'(nx_lo);
      cur_x  = PW'(cx_hi);
    end else if (dir_i.x_neg) begin
      cand_x = -PW'(nx_hi);
      cur_x  = -PW'(cx_lo);
    end else begin
      cand_x = '0;
      cur_x  = '0;
    end
    if (dir_i.y_pos) begin
      cand_y = PW'(ny_lo);
      cur_y  = PW'(cy_hi);
    end else if (dir_i.y_neg) begin
      cand_y = -PW'(ny_hi);
      cur_y  = -PW'(cy_lo);
    end else begin
      cand_y = '0;
      cur_y  = '0;
    end
    dp = DW'(cand_x) + DW'(cand_y) - DW'(cur_x) - DW'(cur_y);

    xa   = XW'(nr_q) - XW'(cur_left_i);
    xb   = XW'(cur_right_i) - XW'(nl_q);
    ya   = XW'(nb_q) - XW'(cur_top_i);
    yb   = XW'(cur_bottom_i) - XW'(nt_q);
    xoff = (xa < xb) ? xa : xb;
    yoff = (ya < yb) ? ya : yb;
    gap_x = COORD_BITS'(-xoff);
    gap_y = COORD_BITS'(-yoff);

    gap_a = '0;
    gap_b = '0;
    if (!focusable_q || is_cur_q || dp[DW-1]) begin
      kind = KIND_SKIP;
    end else if (!xoff[XW-1] && !yoff[XW-1]) begin
      kind = KIND_ZERO;
    end else if (!xoff[XW-1]) begin
      kind  = KIND_AXIS;
      gap_a = gap_y;
    end else if (!yoff[XW-1]) begin
      kind  = KIND_AXIS;
      gap_a = gap_x;
    end else begin
      kind  = KIND_DIAG;
      gap_a = gap_x;
      gap_b = gap_y;
    end
  end

  assign q_entry_o = {last_q, id_q, gap_b, gap_a, dp[DPW-1:0], kind};

endmodule

[rtl/dfs_back.sv]
// Back end: turns queue entries into measures, keeps the running best and
// emits the result on the last candidate. Depends on dfs_pkg, dfs_isqrt.
`timescale 1ns / 1ps

module dfs_back import dfs_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ID_BITS    = DEF_ID_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ent_width(COORD_BITS, ID_BITS)-1:0] q_entry_i,
  input  logic                       q_empty_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_found_o,
  output logic [ID_BITS-1:0]         out_id_o,
  output logic [MEAS_BITS-1:0]       out_meas_o
);

  localparam int KW     = $bits(kind_e);
  localparam int DPW    = COORD_BITS + 2;
  localparam int SUM_W  = 2 * COORD_BITS + 1;
  localparam int OP_W   = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W = (OP_W + 1) / 2;
  localparam int SUMW   = ((DPW + FRAC_BITS > ROOT_W) ? DPW + FRAC_BITS : ROOT_W) + 1;
  localparam int MW     = (SUMW > MEAS_BITS) ? SUMW : MEAS_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_ROOT = 6'b001000,
    ST_MEAS = 6'b010000,
    ST_UPD  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  kind_e                   kind_q, kind_d;
  logic [DPW-1:0]          dp_q, dp_d;
  logic [COORD_BITS-1:0]   a_q, a_d, b_q, b_d;
  logic [ID_BITS-1:0]      id_q, id_d;
  logic                    last_q, last_d;
  logic [2*COORD_BITS-1:0] sq_q, sq_d;
  logic [ROOT_W-1:0]       gap_q, gap_d;
  logic [MEAS_BITS-1:0]    meas_q, meas_d;

  logic [MEAS_BITS-1:0]    best_meas_q, best_meas_d;
  logic [ID_BITS-1:0]      best_id_q, best_id_d;
  logic                    found_q, found_d;

  logic                    out_valid_q, out_valid_d, out_found_q, out_found_d;
  logic [ID_BITS-1:0]      out_id_q, out_id_d;
  logic [MEAS_BITS-1:0]    out_meas_q, out_meas_d;

  logic [COORD_BITS-1:0]   mul_a;
  logic [2*COORD_BITS-1:0] mul_p;
  logic [SUM_W-1:0]        sqrt_sum;
  logic                    sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;
  logic [MW-1:0]           meas_sum;
  logic                    win, new_found, out_free;
  logic [ID_BITS-1:0]      new_id;
  logic [MEAS_BITS-1:0]    new_meas;

  // single shared squarer: a in SQX, b in SQY
  assign mul_a    = (state_q == ST_SQX) ? a_q : b_q;
  assign mul_p    = mul_a * mul_a;
  assign sqrt_sum = SUM_W'(sq_q) + SUM_W'(mul_p);

  dfs_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .opnd_i  ((2*ROOT_W)'({sqrt_sum, {(2*FRAC_BITS){1'b0}}})),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign meas_sum  = MW'({dp_q, {FRAC_BITS{1'b0}}}) + MW'(gap_q);
  assign win       = (kind_q != KIND_SKIP) && (!found_q || (meas_q < best_meas_q));
  assign new_found = found_q || win;
  assign new_id    = win ? id_q : best_id_q;
  assign new_meas  = win ? meas_q : best_meas_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    dp_d        = dp_q;
    a_d         = a_q;
    b_d         = b_q;
    id_d        = id_q;
    last_d      = last_q;
    sq_d        = sq_q;
    gap_d       = gap_q;
    meas_d      = meas_q;
    best_meas_d = best_meas_q;
    best_id_d   = best_id_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_found_d = out_found_q;
    out_id_d    = out_id_q;
    out_meas_d  = out_meas_q;
    q_pop_o     = 1'b0;
    sqrt_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          kind_d  = kind_e'(q_entry_i[KW-1:0]);
          dp_d    = q_entry_i[KW +: DPW];
          a_d     = q_entry_i[KW+DPW +: COORD_BITS];
          b_d     = q_entry_i[KW+DPW+COORD_BITS +: COORD_BITS];
          id_d    = q_entry_i[KW+DPW+2*COORD_BITS +: ID_BITS];
          last_d  = q_entry_i[KW+DPW+2*COORD_BITS+ID_BITS];
          if (kind_d == KIND_DIAG) begin
            state_d = ST_SQX;
          end else begin
            gap_d   = (kind_d == KIND_AXIS) ?
                      ROOT_W'({a_d, {FRAC_BITS{1'b0}}}) : '0;
            state_d = ST_MEAS;
          end
        end
      end
      ST_SQX: begin
        sq_d    = mul_p;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        sqrt_start = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          gap_d   = sqrt_root;
          state_d = ST_MEAS;
        end
      end
      ST_MEAS: begin
        meas_d  = (meas_sum > MW'(MEAS_SAT)) ? MEAS_SAT : meas_sum[MEAS_BITS-1:0];
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!last_q) begin
          best_meas_d = new_meas;
          best_id_d   = new_id;
          found_d     = new_found;
          state_d     = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = new_found;
          out_id_d    = new_found ? new_id : '0;
          out_meas_d  = new_found ? new_meas : '0;
          best_meas_d = MEAS_NONE;
          best_id_d   = '0;
          found_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      best_meas_q <= MEAS_NONE;
      best_id_q   <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      best_meas_q <= best_meas_d;
      best_id_q   <= best_id_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    dp_q        <= dp_d;
    a_q         <= a_d;
    b_q         <= b_d;
    id_q        <= id_d;
    last_q      <= last_d;
    sq_q        <= sq_d;
    gap_q       <= gap_d;
    meas_q      <= meas_d;
    out_found_q <= out_found_d;
    out_id_q    <= out_id_d;
    out_meas_q  <= out_meas_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_id_o    = out_id_q;
  assign out_meas_o  = out_meas_q;

endmodule

[rtl/directional_focus_search_unit.sv]
// Directional focus search unit: top level with configuration registers.
// Depends on dfs_pkg, dfs_front, dfs_queue, dfs_back and the assertion macros.
`timescale 1ns / 1ps
`include "directional_focus_search_unit_macros.svh"

// Picks the next keyboard-focus rectangle in a search direction. Write the
// current rectangle and the direction through the cfg port while the unit is
// idle, then stream candidate rectangles in; the transaction flagged tlast
// closes the search and produces exactly one result transaction carrying
// found, the winning id and its measure (projection gap plus edge gap, 1/16
// pixel units, saturated at 2^22-2). The first candidate with the smallest
// measure wins; with no winner, id and measure read zero. The front end
// takes one candidate transaction per cycle, while the queue is not full,
// into a 4-entry queue. The back end walks every candidate through IDLE,
// MEAS and UPD; one that sits diagonally off a corner also passes SQX and
// SQY and waits in ROOT on the bit-serial square root, which yields one
// root bit per cycle. The result sits in an output register, so the back
// end moves on while it waits to be taken.

module directional_focus_search_unit import dfs_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ID_BITS    = DEF_ID_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  // candidate stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: cand_left, cand_top, cand_right, cand_bottom, cand_id (low bit up)
  input  logic [((4*COORD_BITS+ID_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: cand_focusable, cand_is_current (low bit up)
  input  logic [1:0]              s_axis_tuser,
  input  logic                    s_axis_tlast,
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // tdata: best_id, best_measure (low bit up)
  output logic [((ID_BITS+MEAS_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: found
  output logic [0:0]              m_axis_tuser
);

  localparam int ENT_W = ent_width(COORD_BITS, ID_BITS);
  localparam int OUT_W = ((ID_BITS + MEAS_BITS + 7) / 8) * 8;

  // Configuration registers
  logic signed [COORD_BITS-1:0] cur_left_q, cur_top_q, cur_right_q, cur_bottom_q;
  logic [1:0]                   dir_x_q, dir_y_q;
  dir_t                         dir;

  // Front/back plumbing
  logic                 q_push, q_full, q_pop, q_empty;
  logic [ENT_W-1:0]     q_wr_data, q_rd_data;
  logic                 out_found;
  logic [ID_BITS-1:0]   out_id;
  logic [MEAS_BITS-1:0] out_meas;

  // The user must write only while idle; the unit does not enforce it, and the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_left_q   <= '0;
      cur_top_q    <= '0;
      cur_right_q  <= '0;
      cur_bottom_q <= '0;
      dir_x_q      <= '0;
      dir_y_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CUR_LEFT:   cur_left_q   <= cfg_data_i;
        REG_CUR_TOP:    cur_top_q    <= cfg_data_i;
        REG_CUR_RIGHT:  cur_right_q  <= cfg_data_i;
        REG_CUR_BOTTOM: cur_bottom_q <= cfg_data_i;
        REG_DIR_X:      dir_x_q      <= cfg_data_i[1:0];
        REG_DIR_Y:      dir_y_q      <= cfg_data_i[1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // 01 -> +1, 00 -> none, 1x -> -1 (the -2 code counts as -1)
  assign dir.x_pos = (dir_x_q == 2'b01);
  assign dir.x_neg = dir_x_q[1];
  assign dir.y_pos = (dir_y_q == 2'b01);
  assign dir.y_neg = dir_y_q[1];

  dfs_front #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .cand_left_i       (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
    .cand_top_i        (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
    .cand_right_i      (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
    .cand_bottom_i     (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
    .cand_focusable_i  (s_axis_tuser[0]),
    .cand_is_current_i (s_axis_tuser[1]),
    .cand_id_i         (s_axis_tdata[4*COORD_BITS +: ID_BITS]),
    .last_i            (s_axis_tlast),
    .cur_left_i        (cur_left_q),
    .cur_top_i         (cur_top_q),
    .cur_right_i       (cur_right_q),
    .cur_bottom_i      (cur_bottom_q),
    .dir_i             (dir),
    .q_push_o          (q_push),
    .q_entry_o         (q_wr_data),
    .q_full_i          (q_full)
  );

  dfs_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr_data),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .rd_data_o (q_rd_data),
    .empty_o   (q_empty)
  );

  dfs_back #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_entry_i   (q_rd_data),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (out_found),
    .out_id_o    (out_id),
    .out_meas_o  (out_meas)
  );

  assign m_axis_tdata    = OUT_W'({out_meas, out_id});
  assign m_axis_tuser[0] = out_found;

  // Front never pushes into a full queue.
  `DFS_ASSERT_NEVER(a_queue_no_overflow, q_push && q_full, "queue overflow")
  // Input backpressure only comes from a full queue.
  `DFS_ASSERT_IMPL(a_stall_needs_full, !s_axis_tready, q_full, "input stalled, queue not full")
  // No winner means id and measure read zero.
  `DFS_ASSERT_IMPL(a_none_is_zero, m_axis_tvalid && !out_found,
                   (out_id == '0) && (out_meas == '0), "empty result not zeroed")
  // A winner's measure stays clear of the none code.
  `DFS_ASSERT_IMPL(a_found_not_none, m_axis_tvalid && out_found,
                   out_meas != MEAS_NONE, "winner carries none code")

endmodule

[dv/tb_directional_focus_search_unit.sv]
// Self-checking testbench for directional_focus_search_unit: directed and random searches.
// Depends on dfs_pkg and the RTL of the unit; the scoreboard class predicts each winner.
`timescale 1ns / 1ps

import dfs_pkg::*;

typedef struct {
  logic signed [DEF_COORD_BITS-1:0] left;
  logic signed [DEF_COORD_BITS-1:0] top;
  logic signed [DEF_COORD_BITS-1:0] right;
  logic signed [DEF_COORD_BITS-1:0] bottom;
  logic                             focusable;
  logic                             is_current;
  logic [DEF_ID_BITS-1:0]           id;
  logic                             last;
} cand_t;

typedef struct {
  logic                   found;
  logic [DEF_ID_BITS-1:0] id;
  logic [MEAS_BITS-1:0]   measure;
} winner_t;

// Tracks the running search and keeps the winners still owed by the unit.
class winner_board;
  logic signed [DEF_COORD_BITS-1:0] cur_l, cur_t, cur_r, cur_b;
  logic [1:0]                       dir_x, dir_y;
  logic                             run_found;
  logic [DEF_ID_BITS-1:0]           run_id;
  logic [MEAS_BITS-1:0]             run_measure;
  winner_t                          pending_winners[$];
  int                               errors;

  function new();
    cur_l = '0;
    cur_t = '0;
    cur_r = '0;
    cur_b = '0;
    dir_x = '0;
    dir_y = '0;
    run_found = 1'b0;
    run_id = '0;
    run_measure = MEAS_NONE;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DEF_COORD_BITS-1:0] data);
    case (idx)
      REG_CUR_LEFT:   cur_l = data;
      REG_CUR_TOP:    cur_t = data;
      REG_CUR_RIGHT:  cur_r = data;
      REG_CUR_BOTTOM: cur_b = data;
      REG_DIR_X:      dir_x = data[1:0];
      REG_DIR_Y:      dir_y = data[1:0];
      default: ;
    endcase
  endfunction

  // 2'b10 counts as -1, same as 2'b11
  function longint heading(logic [1:0] d);
    case (d)
      2'b00:   return 0;
      2'b01:   return 1;
      default: return -1;
    endcase
  endfunction

  function longint lesser(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function longint greater(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // floor(sqrt(n)), one root bit per pass from the top
  function longint unsigned root_floor(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 22; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function void note_candidate(cand_t c);
    longint dx, dy, nl, nt, nr, nb, cl, ct, cr, cb;
    longint lead, trail, proj, xoff, yoff;
    longint unsigned edge_gap, score;
    winner_t w;
    dx = heading(dir_x);
    dy = heading(dir_y);
    nl = c.left;
    nt = c.top;
    nr = c.right;
    nb = c.bottom;
    cl = cur_l;
    ct = cur_t;
    cr = cur_r;
    cb = cur_b;
    if (c.focusable && !c.is_current) begin
      lead  = lesser(nl * dx, nr * dx) + lesser(nt * dy, nb * dy);
      trail = greater(cl * dx, cr * dx) + greater(ct * dy, cb * dy);
      proj  = lead - trail;
      if (proj >= 0) begin
        xoff = lesser(nr - cl, cr - nl);
        yoff = lesser(nb - ct, cb - nt);
        if (xoff >= 0 && yoff >= 0) edge_gap = 0;
        else if (xoff >= 0) edge_gap = (-yoff) << FRAC_BITS;
        else if (yoff >= 0) edge_gap = (-xoff) << FRAC_BITS;
        else edge_gap = root_floor((xoff * xoff + yoff * yoff) << (2 * FRAC_BITS));
        score = (proj << FRAC_BITS) + edge_gap;
        if (score > MEAS_SAT) score = MEAS_SAT;
        // strict compare: earliest candidate keeps a tie
        if (!run_found || score < run_measure) begin
          run_measure = MEAS_BITS'(score);
          run_id = c.id;
          run_found = 1'b1;
        end
      end
    end
    if (c.last) begin
      w.found   = run_found;
      w.id      = run_found ? run_id : '0;
      w.measure = run_found ? run_measure : '0;
      pending_winners.insert(pending_winners.size(), w);
      run_found = 1'b0;
      run_id = '0;
      run_measure = MEAS_NONE;
    end
  endfunction

  function void check_winner(logic found, logic [DEF_ID_BITS-1:0] id,
                             logic [MEAS_BITS-1:0] measure);
    winner_t w;
    if (pending_winners.size() == 0) begin
      $error("unexpected result transaction: found %0d best_id %0d best_measure %0d",
             found, id, measure);
      errors++;
      return;
    end
    w = pending_winners.pop_front();
    if (found !== w.found) begin
      $error("found: expected %0d, got %0d", w.found, found);
      errors++;
    end
    if (id !== w.id) begin
      $error("best_id: expected %0d, got %0d", w.id, id);
      errors++;
    end
    if (measure !== w.measure) begin
      $error("best_measure: expected %0d, got %0d", w.measure, measure);
      errors++;
    end
  endfunction
endclass

module tb_directional_focus_search_unit;

  localparam int CW = DEF_COORD_BITS;
  localparam int IW = DEF_ID_BITS;
  localparam int IN_DATA_W  = ((4 * CW + IW + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((IW + MEAS_BITS + 7) / 8) * 8;
  // worst case: a queue full of corner candidates, each through the square root
  localparam int DRAIN_CYCLES = QUEUE_DEPTH * (CW + 11) + 16;
  // ~725 transactions, each bounded by its work plus the longest gaps on
  // both sides, plus the hold-off and the drains; taken several times over
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 68;
  localparam int HOLD_PHASE   = 5;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CW-1:0]           cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;
  logic [1:0]              s_axis_tuser;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic [0:0]              m_axis_tuser;

  winner_board board = new();
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;   // receiver hold-off request, in cycles
  int unsigned rx_stall = 0;
  bit          bursty = 1'b1; // idling on both sides when set

  directional_focus_search_unit #(
    .COORD_BITS(CW),
    .ID_BITS   (IW)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor: tdata = {best_measure, best_id}, tuser = found
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_winner(m_axis_tuser[0], m_axis_tdata[IW-1:0],
                         m_axis_tdata[IW+MEAS_BITS-1:IW]);
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int unsigned send_gap();
    if (!bursty || $urandom_range(0, 99) < 60) return 0;
    return pick_gap();
  endfunction

  // Receiver: a requested hold-off wins over the random stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (bursty && $urandom_range(0, 99) < 20) rx_stall = pick_gap();
      end
    end
  end

  function automatic logic signed [CW-1:0] clip(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[CW-1:0];
  endfunction

  function automatic cand_t mk_cand(int l, int t, int r, int b, bit foc, bit cur,
                                    logic [IW-1:0] id, bit last);
    cand_t c;
    c.left = clip(l);
    c.top = clip(t);
    c.right = clip(r);
    c.bottom = clip(b);
    c.focusable = foc;
    c.is_current = cur;
    c.id = id;
    c.last = last;
    return c;
  endfunction

  // Candidate placed around the current rectangle: overlaps, side and corner gaps
  function automatic cand_t near_cand();
    int l, t, r, b, s;
    l = int'(board.cur_l) + int'($urandom_range(0, 1600)) - 800;
    t = int'(board.cur_t) + int'($urandom_range(0, 1600)) - 800;
    r = l + int'($urandom_range(0, 400));
    b = t + int'($urandom_range(0, 400));
    if ($urandom_range(0, 9) == 0) begin
      s = l;
      l = r;
      r = s;
    end
    if ($urandom_range(0, 9) == 0) begin
      s = t;
      t = b;
      b = s;
    end
    return mk_cand(l, t, r, b, $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0,
                   IW'($urandom), 1'b0);
  endfunction

  function automatic cand_t wild_cand();
    cand_t c;
    c.left = CW'($urandom);
    c.top = CW'($urandom);
    c.right = CW'($urandom);
    c.bottom = CW'($urandom);
    c.focusable = 1'($urandom);
    c.is_current = 1'($urandom);
    c.id = IW'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Direction registers carry random junk above bit 1
  task automatic set_focus(int l, int t, int r, int b, logic [1:0] dx, logic [1:0] dy);
    logic [CW-1:0] junk;
    write_reg(REG_CUR_LEFT, clip(l));
    write_reg(REG_CUR_TOP, clip(t));
    write_reg(REG_CUR_RIGHT, clip(r));
    write_reg(REG_CUR_BOTTOM, clip(b));
    junk = CW'($urandom);
    write_reg(REG_DIR_X, {junk[CW-1:2], dx});
    junk = CW'($urandom);
    write_reg(REG_DIR_Y, {junk[CW-1:2], dy});
  endtask

  // One candidate transaction; tdata = {id, bottom, right, top, left}
  task automatic send_cand(cand_t c, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.id, c.bottom, c.right, c.top, c.left};
    s_axis_tuser  <= {c.is_current, c.focusable};
    s_axis_tlast  <= c.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_candidate(c);
  endtask

  // Stop sending, collect every owed winner, then let the back end run dry
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_winners.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_focus();
    int l, t, r, b, s;
    case ($urandom_range(0, 2))
      0: begin
        l = int'($urandom_range(0, 4000)) - 2000;
        t = int'($urandom_range(0, 4000)) - 2000;
        r = l + int'($urandom_range(0, 300));
        b = t + int'($urandom_range(0, 300));
      end
      1: begin
        l = int'($urandom_range(0, 65535)) - 32768;
        t = int'($urandom_range(0, 65535)) - 32768;
        r = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
      end
      default: begin
        // inverted rectangle
        r = int'($urandom_range(0, 4000)) - 2000;
        b = int'($urandom_range(0, 4000)) - 2000;
        l = r + int'($urandom_range(1, 300));
        t = b + int'($urandom_range(1, 300));
      end
    endcase
    set_focus(l, t, r, b, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  initial begin
    cand_t c;
    int    sent, len;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: searching right from a plain rectangle
    bursty = 1'b0;
    set_focus(0, 0, 100, 50, 2'b01, 2'b00);
    send_cand(mk_cand(200, 0, 300, 50, 1, 0, 16'h0001, 0), 0);
    send_cand(mk_cand(200, 0, 300, 50, 1, 0, 16'h0002, 0), 0);   // tie, first stays
    send_cand(mk_cand(110, 0, 120, 50, 0, 0, 16'h0003, 0), 0);   // not focusable
    send_cand(mk_cand(110, 0, 120, 50, 1, 1, 16'h0004, 0), 0);   // current control
    send_cand(mk_cand(-300, 0, -200, 50, 1, 0, 16'h0005, 1), 0); // behind
    send_cand(mk_cand(100, 10, 150, 40, 1, 0, 16'hFFFF, 1), 0);  // full overlap
    send_cand(mk_cand(-300, 0, -200, 50, 1, 0, 16'hFFFF, 1), 0); // no winner
    send_cand(mk_cand(150, 100, 200, 150, 1, 0, 16'h1234, 0), 0);  // corner gap
    send_cand(mk_cand(400, -200, 500, -100, 1, 0, 16'h4321, 1), 0);
    // direction code 2'b10 and coordinate extremes
    settle();
    set_focus(32767, 32767, 32767, 32767, 2'b10, 2'b11);
    send_cand(mk_cand(-32768, -32768, -32768, -32768, 1, 0, 16'h8000, 0), 0);
    send_cand(mk_cand(-32768, 32767, 32767, -32768, 1, 0, 16'h7FFF, 1), 0);
    // zero direction around an inverted current rectangle
    settle();
    set_focus(50, 50, -50, -50, 2'b00, 2'b00);
    send_cand(mk_cand(1000, 1000, 1100, 1100, 1, 0, 16'h00AA, 0), 0);
    send_cand(mk_cand(-50, -50, 50, 50, 1, 0, 16'h0055, 0), 0);
    send_cand(mk_cand(0, 300, 10, 310, 1, 0, 16'h5555, 1), 0);

    // --- random phases, each under its own focus setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      bursty = (ph % 3) != 2;
      case (ph)
        0: set_focus(32767, 32767, 32767, 32767, 2'b01, 2'b01);
        1: set_focus(-32768, -32768, -32768, -32768, 2'b11, 2'b10);
        default: random_focus();
      endcase
      if (ph == HOLD_PHASE) begin
        // receiver holds off while one-candidate searches pile up
        rx_hold = 400;
        repeat (30) begin
          c = near_cand();
          c.last = 1'b1;
          send_cand(c, 0);
        end
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            c = ($urandom_range(0, 3) != 0) ? near_cand() : wild_cand();
            c.last = (k == len - 1);
            send_cand(c, send_gap());
            sent++;
          end
        end else begin
          send_cand(wild_cand(), send_gap());
          sent++;
        end
      end
      // close any search left open by a stray candidate
      c = near_cand();
      c.last = 1'b1;
      send_cand(c, send_gap());
    end

    settle();
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
